// ===== rtl/core/ptl_pkg.sv =====
// Shared types and constants for the proportional text layout block.
package ptl_pkg;

    // Glyph strip width in pixels; loaded offsets clamp to one below it
    localparam int unsigned STRIP_WIDTH = 4096;
    localparam logic [16:0] OFFSET_LIMIT = 17'(STRIP_WIDTH - 1);

    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned WIDTH_W  = 8;
    localparam int unsigned PEN_W    = 16;

    // Item function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_CHAR  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_TAB_SHIFT    = 2'd0;
    localparam logic [1:0] REG_LINE_PITCH   = 2'd1;
    localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd2;

    localparam logic [3:0] TAB_SHIFT_RESET    = 4'd6;
    localparam logic [7:0] LINE_PITCH_RESET   = 8'd24;
    localparam logic [7:0] GLYPH_HEIGHT_RESET = 8'd22;

    // Character codes with special handling
    localparam logic [6:0] CHAR_TAB     = 7'd9;
    localparam logic [6:0] CHAR_NEWLINE = 7'd10;
    localparam logic [6:0] CHAR_SPACE   = 7'd32;
    localparam logic [6:0] CHAR_LAST    = 7'd126;

    localparam logic [PEN_W-1:0] PEN_MAX = '1;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [WIDTH_W-1:0]  width;
    } ptl_entry_t;

endpackage

// ===== rtl/core/ptl_glyph_table.sv =====
// Glyph table memory: strip offset and width per code, with per-entry valid bits.
module ptl_glyph_table #(
    parameter int NUM_CODES = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(NUM_CODES)-1:0]  wr_idx,
    input  ptl_pkg::ptl_entry_t           wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(NUM_CODES)-1:0]  rd_idx,
    output ptl_pkg::ptl_entry_t           rd_data
);
    import ptl_pkg::*;

    ptl_entry_t           mem [NUM_CODES];
    logic [NUM_CODES-1:0] loaded_reg;
    ptl_entry_t           rd_word_reg;
    logic                 rd_loaded_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            rd_loaded_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                loaded_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_loaded_reg <= loaded_reg[rd_idx];
            end
        end
    end

    // Entries never loaded read as zero
    assign rd_data = rd_loaded_reg ? rd_word_reg : '0;

endmodule

// ===== rtl/core/proportional_text_layout.sv =====
// Top level of the proportional font text layout engine.
//
// Input channel (in_valid / in_stall) takes one word per item: func selects
// a table load, a string start or a character to lay out. Output channel
// (out_valid / out_stall) returns one word per item with the blit command
// (blit_valid low when nothing is drawn) and the running bounding box.
// Configuration writes (cfg_write, cfg_index, cfg_data) set tab spacing,
// line pitch and glyph height; write them only while the block is idle.
//
// Accepted items pass the layout stage, then the output register.
// Throughput is one item per cycle while out_stall is low; the glyph table
// is read at accept and the layout stage updates pen, tab and box from it.
// When the receiver stalls, the finished word holds in the output register
// and one more item may wait in the table-read stage; in_stall rises only
// when both are full. Reset clears the pen, the widest-line width, the
// glyph table's loaded marks (all read as zero) and restores register defaults.
module proportional_text_layout #(
    parameter int NUM_CODES = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic [6:0]                        char_code,
    input  logic [ptl_pkg::OFFSET_W-1:0]      entry_offset,
    input  logic [ptl_pkg::WIDTH_W-1:0]       entry_width,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              blit_valid,
    output logic [ptl_pkg::OFFSET_W-1:0]      src_offset,
    output logic [ptl_pkg::WIDTH_W-1:0]       blit_width,
    output logic [ptl_pkg::PEN_W-1:0]         dest_x,
    output logic [ptl_pkg::PEN_W-1:0]         dest_y,
    output logic [ptl_pkg::PEN_W-1:0]         box_width,
    output logic [ptl_pkg::PEN_W-1:0]         box_height
);
    import ptl_pkg::*;

    localparam int IDX_W = $clog2(NUM_CODES);
    localparam logic [8:0] CODE_COUNT = 9'(NUM_CODES);

    // Configuration registers
    logic [3:0] tab_shift_reg;
    logic [7:0] line_pitch_reg;
    logic [7:0] glyph_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_shift_reg    <= TAB_SHIFT_RESET;
            line_pitch_reg   <= LINE_PITCH_RESET;
            glyph_height_reg <= GLYPH_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TAB_SHIFT:    tab_shift_reg    <= cfg_data[3:0];
                REG_LINE_PITCH:   line_pitch_reg   <= cfg_data;
                REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Accept stage: table write for loads, table read for everything
    logic       in_accept;
    logic       advance;
    logic [7:0] code_ext;
    logic       in_code_fits;
    logic       load_en;
    ptl_entry_t load_entry;
    ptl_entry_t table_word;

    assign in_accept    = in_valid && !in_stall;
    assign code_ext     = {1'b0, char_code};
    assign in_code_fits = {2'b00, char_code} < CODE_COUNT;
    assign load_en      = in_accept && (func == FUNC_LOAD) && in_code_fits;

    always_comb
    begin
        load_entry.width = entry_width;
        if ({5'b0, entry_offset} > OFFSET_LIMIT)
        begin
            load_entry.offset = OFFSET_LIMIT[OFFSET_W-1:0];
        end
        else
        begin
            load_entry.offset = entry_offset;
        end
    end

    ptl_glyph_table #(
        .NUM_CODES (NUM_CODES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_en),
        .wr_idx  (code_ext[IDX_W-1:0]),
        .wr_data (load_entry),
        .rd_en   (in_accept),
        .rd_idx  (code_ext[IDX_W-1:0]),
        .rd_data (table_word)
    );

    // Layout stage: table data is ready, pen state lives here
    logic       s1_valid_reg;
    logic [1:0] s1_func_reg;
    logic [6:0] s1_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg <= func;
            s1_code_reg <= char_code;
        end
    end

    assign advance  = s1_valid_reg && (!out_valid || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    logic [PEN_W-1:0] pen_x_reg;
    logic [PEN_W-1:0] pen_y_reg;
    logic [PEN_W-1:0] widest_reg;
    logic [PEN_W-1:0] pen_x_next;
    logic [PEN_W-1:0] pen_y_next;
    logic [PEN_W-1:0] widest_next;

    ptl_entry_t       glyph;
    logic             draw;
    logic [PEN_W:0]   adv_sum;
    logic [PEN_W:0]   tab_step;
    logic [PEN_W:0]   tab_sum;
    logic [PEN_W:0]   pitch_sum;
    logic [PEN_W:0]   height_sum;
    logic [PEN_W-1:0] box_w_next;
    logic [PEN_W-1:0] box_h_next;

    always_comb
    begin
        // Codes beyond the table read as an empty glyph
        glyph      = ({2'b00, s1_code_reg} < CODE_COUNT) ? table_word : '0;
        adv_sum    = {1'b0, pen_x_reg} + {9'b0, glyph.width};
        tab_step   = 17'(1) << tab_shift_reg;
        tab_sum    = ({1'b0, pen_x_reg} + tab_step) & ~(tab_step - 17'(1));
        pitch_sum  = {1'b0, pen_y_reg} + {9'b0, line_pitch_reg};

        draw        = 1'b0;
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        widest_next = widest_reg;

        case (s1_func_reg)
            FUNC_START:
            begin
                pen_x_next  = '0;
                pen_y_next  = '0;
                widest_next = '0;
            end
            FUNC_CHAR:
            begin
                if (s1_code_reg inside {[CHAR_SPACE:CHAR_LAST]})
                begin
                    draw       = 1'b1;
                    pen_x_next = adv_sum[PEN_W] ? PEN_MAX : adv_sum[PEN_W-1:0];
                end
                else if (s1_code_reg == CHAR_TAB)
                begin
                    pen_x_next = tab_sum[PEN_W] ? PEN_MAX : tab_sum[PEN_W-1:0];
                end
                else if (s1_code_reg == CHAR_NEWLINE)
                begin
                    widest_next = (pen_x_reg > widest_reg) ? pen_x_reg : widest_reg;
                    pen_x_next  = '0;
                    pen_y_next  = pitch_sum[PEN_W] ? PEN_MAX : pitch_sum[PEN_W-1:0];
                end
            end
            default:
            begin
                draw = 1'b0;
            end
        endcase

        box_w_next = (pen_x_next > widest_next) ? pen_x_next : widest_next;
        height_sum = {1'b0, pen_y_next} + {9'b0, glyph_height_reg};
        box_h_next = height_sum[PEN_W] ? PEN_MAX : height_sum[PEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            widest_reg <= '0;
        end
        else if (advance)
        begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            widest_reg <= widest_next;
        end
    end

    // Output register: hold the word while the receiver stalls
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    logic                blit_valid_reg;
    logic [OFFSET_W-1:0] src_offset_reg;
    logic [WIDTH_W-1:0]  blit_width_reg;
    logic [PEN_W-1:0]    dest_x_reg;
    logic [PEN_W-1:0]    dest_y_reg;
    logic [PEN_W-1:0]    box_width_reg;
    logic [PEN_W-1:0]    box_height_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            blit_valid_reg <= draw;
            src_offset_reg <= draw ? glyph.offset : '0;
            blit_width_reg <= draw ? glyph.width : '0;
            dest_x_reg     <= draw ? pen_x_reg : '0;
            dest_y_reg     <= draw ? pen_y_reg : '0;
            box_width_reg  <= box_w_next;
            box_height_reg <= box_h_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign blit_valid = blit_valid_reg;
    assign src_offset = src_offset_reg;
    assign blit_width = blit_width_reg;
    assign dest_x     = dest_x_reg;
    assign dest_y     = dest_y_reg;
    assign box_width  = box_width_reg;
    assign box_height = box_height_reg;

endmodule
